>>> rtl/taps_pkg.sv
// Shared constants, codes and payload types of the timed action plan sequencer.
package taps_pkg;

    localparam int MAX_STEPS = 16;
    localparam int IDX_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int POS_W     = $clog2(MAX_STEPS + 1);
    localparam int CNT_W     = 5;
    localparam int TIME_W    = 32;
    localparam int UNIT_W    = 8;
    localparam int ACT_W     = 3;
    localparam int LEN_W     = 8;
    localparam int SLOT_W    = 4;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_CANCEL = 2'd3;

    localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WAIT     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PUMP_ON  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PUMP_OFF = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_READY     = 3'd1,
        ST_RUNNING   = 3'd2,
        ST_WAITING   = 3'd3,
        ST_SUCCEEDED = 3'd4,
        ST_FAILED    = 3'd5,
        ST_CANCELLED = 3'd6
    } run_state_t;

    typedef enum logic [2:0] {
        ER_NONE    = 3'd0,
        ER_BUSY    = 3'd1,
        ER_CONTEXT = 3'd2,
        ER_PLAN    = 3'd3,
        ER_STEP    = 3'd4
    } err_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] now_ms;
        logic [SLOT_W-1:0] entry_index;
        logic [ACT_W-1:0]  entry_action;
        logic [TIME_W-1:0] entry_delay_ms;
        logic [UNIT_W-1:0] entry_unit;
        logic [LEN_W-1:0]  plan_length;
        logic              plan_needs_pump;
        logic              plan_ok;
        logic              ids_ok;
    } taps_cmd_t;

    typedef struct packed {
        logic              accepted;
        logic [2:0]        run_state;
        logic [2:0]        error_code;
        logic [POS_W-1:0]  step_position;
        logic              pump_required;
        logic              pump_planned_on;
        logic [UNIT_W-1:0] pump_unit;
        logic [CNT_W-1:0]  pump_transitions;
        logic [TIME_W-1:0] progress_time_ms;
        logic [TIME_W-1:0] completed_time_ms;
    } taps_rsp_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [TIME_W-1:0] delay;
        logic [UNIT_W-1:0] unit;
    } plan_entry_t;

endpackage

>>> rtl/taps_if.sv
// Valid/ready channel interfaces for command and response transfers.
interface taps_cmd_if;
    logic                valid;
    logic                ready;
    taps_pkg::taps_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface taps_rsp_if;
    logic                valid;
    logic                ready;
    taps_pkg::taps_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/timed_action_plan_sequencer_top.sv
// Timed action plan sequencer: plan memory, run control and response register.
// A command passes IDLE, EXEC and OUT before its response is registered; a good load
// adds a scan of the plan memory, reading up to plan_length entries through its single read port.
// Commands are taken one at a time: a new one only after the last has left OUT.
// The response register holds one result, so a new command transfer can happen
// while the previous response is still waiting for its sink.
// Reset (rst_n, async low): run context idle, all times and the pump record zero;
// plan memory contents stay undefined until written.
module timed_action_plan_sequencer_top (
    input logic         clk,
    input logic         rst_n,
    taps_cmd_if.sink    cmd,
    taps_rsp_if.source  rsp
);
    import taps_pkg::*;

    // Control sequencer: IDLE takes a command (and reads the plan entry at the
    // current position), EXEC applies it, SCAN walks the plan on a good load,
    // OUT moves the snapshot into the response register.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_OUT
    } fsm_t;

    fsm_t              state_reg, state_next;
    taps_cmd_t         req_reg, req_next;
    logic              ok_reg, ok_next;

    // Run context
    run_state_t        exec_state_reg, exec_state_next;
    err_t              last_error_reg, last_error_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic [POS_W-1:0]  plan_size_reg, plan_size_next;
    logic              wait_armed_reg, wait_armed_next;
    logic [TIME_W-1:0] wait_start_reg, wait_start_next;
    logic [TIME_W-1:0] progress_reg, progress_next;
    logic [TIME_W-1:0] finished_reg, finished_next;
    logic              pump_req_reg, pump_req_next;
    logic              pump_on_reg, pump_on_next;
    logic [UNIT_W-1:0] pump_unit_reg, pump_unit_next;
    logic [CNT_W-1:0]  pump_count_reg, pump_count_next;

    // Load-time scan for the first pump entry
    logic [POS_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              scan_vld_reg, scan_vld_next;
    logic              scan_found_reg, scan_found_next;
    logic              scan_issue;

    // Response register
    logic              rsp_valid_reg, rsp_valid_next;
    taps_rsp_t         rsp_data_reg, rsp_data_next;

    // Plan memory: one write port, one registered read port
    plan_entry_t       plan_mem [MAX_STEPS];
    plan_entry_t       rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    plan_entry_t       mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;

    logic              active;
    logic              slot_ok;
    logic [TIME_W-1:0] elapsed;
    logic [POS_W-1:0]  pos_inc;

    assign active  = (exec_state_reg == ST_READY) || (exec_state_reg == ST_RUNNING) ||
                     (exec_state_reg == ST_WAITING);
    assign slot_ok = (int'(req_reg.entry_index) < MAX_STEPS);
    // wrapping millisecond difference
    assign elapsed = req_reg.now_ms - wait_start_reg;
    assign pos_inc = position_reg + POS_W'(1);

    assign scan_issue = (state_reg == S_SCAN) && (scan_idx_reg < plan_size_reg) &&
                        !scan_found_reg;

    // Writes land in EXEC; the next command read happens only after OUT, so
    // a read never meets a write to the same entry in flight.
    assign mem_we    = (state_reg == S_EXEC) && (req_reg.mode == MODE_WRITE) &&
                       !active && slot_ok;
    assign mem_waddr = req_reg.entry_index[IDX_W-1:0];
    assign mem_wdata = '{action: req_reg.entry_action,
                         delay:  req_reg.entry_delay_ms,
                         unit:   req_reg.entry_unit};
    assign mem_re    = (state_reg == S_IDLE) || scan_issue;
    // In IDLE the entry at the current position is fetched ahead of a tick;
    // a position past the plan end is never consumed.
    assign mem_raddr = (state_reg == S_SCAN) ? scan_idx_reg[IDX_W-1:0]
                                             : position_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            plan_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= plan_mem[mem_raddr];
        end
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        ok_next         = ok_reg;
        exec_state_next = exec_state_reg;
        last_error_next = last_error_reg;
        position_next   = position_reg;
        plan_size_next  = plan_size_reg;
        wait_armed_next = wait_armed_reg;
        wait_start_next = wait_start_reg;
        progress_next   = progress_reg;
        finished_next   = finished_reg;
        pump_req_next   = pump_req_reg;
        pump_on_next    = pump_on_reg;
        pump_unit_next  = pump_unit_reg;
        pump_count_next = pump_count_reg;
        scan_idx_next   = scan_idx_reg;
        scan_vld_next   = scan_vld_reg;
        scan_found_next = scan_found_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_data_next   = rsp_data_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    req_next   = cmd.data;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                ok_next    = 1'b0;
                state_next = S_OUT;
                case (req_reg.mode)
                    MODE_WRITE:
                    begin
                        ok_next = !active && slot_ok;
                    end

                    MODE_LOAD:
                    begin
                        if (active)
                        begin
                            last_error_next = ER_BUSY;
                        end
                        else
                        begin
                            // fresh context before checking the plan
                            plan_size_next  = '0;
                            exec_state_next = ST_IDLE;
                            last_error_next = ER_NONE;
                            position_next   = '0;
                            wait_armed_next = 1'b0;
                            wait_start_next = '0;
                            progress_next   = '0;
                            finished_next   = '0;
                            pump_req_next   = 1'b0;
                            pump_on_next    = 1'b0;
                            pump_unit_next  = '0;
                            pump_count_next = '0;
                            if (!req_reg.ids_ok)
                            begin
                                exec_state_next = ST_FAILED;
                                last_error_next = ER_CONTEXT;
                                finished_next   = req_reg.now_ms;
                                progress_next   = req_reg.now_ms;
                            end
                            else if (!req_reg.plan_ok ||
                                     (int'(req_reg.plan_length) > MAX_STEPS))
                            begin
                                exec_state_next = ST_FAILED;
                                last_error_next = ER_PLAN;
                                finished_next   = req_reg.now_ms;
                                progress_next   = req_reg.now_ms;
                            end
                            else
                            begin
                                plan_size_next  = POS_W'(req_reg.plan_length);
                                exec_state_next = ST_READY;
                                progress_next   = req_reg.now_ms;
                                pump_req_next   = req_reg.plan_needs_pump;
                                ok_next         = 1'b1;
                                scan_idx_next   = '0;
                                scan_vld_next   = 1'b0;
                                scan_found_next = 1'b0;
                                state_next      = S_SCAN;
                            end
                        end
                    end

                    MODE_TICK:
                    begin
                        if (exec_state_reg == ST_READY)
                        begin
                            exec_state_next = ST_RUNNING;
                            progress_next   = req_reg.now_ms;
                            ok_next         = 1'b1;
                        end
                        else if ((exec_state_reg == ST_RUNNING) ||
                                 (exec_state_reg == ST_WAITING))
                        begin
                            if (position_reg >= plan_size_reg)
                            begin
                                exec_state_next = ST_SUCCEEDED;
                                last_error_next = ER_NONE;
                                finished_next   = req_reg.now_ms;
                                progress_next   = req_reg.now_ms;
                                wait_armed_next = 1'b0;
                                ok_next         = 1'b1;
                            end
                            else if (rd_data_reg.action == ACT_NONE)
                            begin
                                exec_state_next = ST_FAILED;
                                last_error_next = ER_STEP;
                                finished_next   = req_reg.now_ms;
                                progress_next   = req_reg.now_ms;
                                wait_armed_next = 1'b0;
                                ok_next         = 1'b1;
                            end
                            else if ((rd_data_reg.action == ACT_WAIT) && !wait_armed_reg)
                            begin
                                wait_armed_next = 1'b1;
                                wait_start_next = req_reg.now_ms;
                                exec_state_next = ST_WAITING;
                                progress_next   = req_reg.now_ms;
                                ok_next         = 1'b1;
                            end
                            else if ((rd_data_reg.action == ACT_WAIT) &&
                                     (elapsed < rd_data_reg.delay))
                            begin
                                ok_next = 1'b0;
                            end
                            else
                            begin
                                // step consumed: elapsed wait, pump entry or pass
                                if (rd_data_reg.action == ACT_WAIT)
                                begin
                                    wait_armed_next = 1'b0;
                                    exec_state_next = ST_RUNNING;
                                end
                                if ((rd_data_reg.action == ACT_PUMP_ON) ||
                                    (rd_data_reg.action == ACT_PUMP_OFF))
                                begin
                                    pump_req_next  = 1'b1;
                                    pump_unit_next = rd_data_reg.unit;
                                    pump_on_next   = (rd_data_reg.action == ACT_PUMP_ON);
                                    if (pump_count_reg != '1)
                                    begin
                                        pump_count_next = pump_count_reg + CNT_W'(1);
                                    end
                                end
                                position_next = pos_inc;
                                progress_next = req_reg.now_ms;
                                if (pos_inc >= plan_size_reg)
                                begin
                                    exec_state_next = ST_SUCCEEDED;
                                    last_error_next = ER_NONE;
                                    finished_next   = req_reg.now_ms;
                                    wait_armed_next = 1'b0;
                                end
                                ok_next = 1'b1;
                            end
                        end
                    end

                    MODE_CANCEL:
                    begin
                        if (active)
                        begin
                            exec_state_next = ST_CANCELLED;
                            finished_next   = req_reg.now_ms;
                            progress_next   = req_reg.now_ms;
                            wait_armed_next = 1'b0;
                            ok_next         = 1'b1;
                        end
                    end

                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end

            S_SCAN:
            begin
                // one read issued per cycle, its data checked once registered;
                // a read in flight after the hit is dropped
                scan_vld_next = scan_issue;
                if (scan_issue)
                begin
                    scan_idx_next = scan_idx_reg + POS_W'(1);
                end
                if (scan_vld_reg && !scan_found_reg &&
                    ((rd_data_reg.action == ACT_PUMP_ON) ||
                     (rd_data_reg.action == ACT_PUMP_OFF)))
                begin
                    pump_unit_next  = rd_data_reg.unit;
                    scan_found_next = 1'b1;
                end
                if (!scan_issue && !scan_vld_reg)
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next                  = 1'b1;
                    rsp_data_next.accepted          = ok_reg;
                    rsp_data_next.run_state         = exec_state_reg;
                    rsp_data_next.error_code        = last_error_reg;
                    rsp_data_next.step_position     = position_reg;
                    rsp_data_next.pump_required     = pump_req_reg;
                    rsp_data_next.pump_planned_on   = pump_on_reg;
                    rsp_data_next.pump_unit         = pump_unit_reg;
                    rsp_data_next.pump_transitions  = pump_count_reg;
                    rsp_data_next.progress_time_ms  = progress_reg;
                    rsp_data_next.completed_time_ms = finished_reg;
                    state_next                      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= '0;
            ok_reg         <= 1'b0;
            exec_state_reg <= ST_IDLE;
            last_error_reg <= ER_NONE;
            position_reg   <= '0;
            plan_size_reg  <= '0;
            wait_armed_reg <= 1'b0;
            wait_start_reg <= '0;
            progress_reg   <= '0;
            finished_reg   <= '0;
            pump_req_reg   <= 1'b0;
            pump_on_reg    <= 1'b0;
            pump_unit_reg  <= '0;
            pump_count_reg <= '0;
            scan_idx_reg   <= '0;
            scan_vld_reg   <= 1'b0;
            scan_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            ok_reg         <= ok_next;
            exec_state_reg <= exec_state_next;
            last_error_reg <= last_error_next;
            position_reg   <= position_next;
            plan_size_reg  <= plan_size_next;
            wait_armed_reg <= wait_armed_next;
            wait_start_reg <= wait_start_next;
            progress_reg   <= progress_next;
            finished_reg   <= finished_next;
            pump_req_reg   <= pump_req_next;
            pump_on_reg    <= pump_on_next;
            pump_unit_reg  <= pump_unit_next;
            pump_count_reg <= pump_count_next;
            scan_idx_reg   <= scan_idx_next;
            scan_vld_reg   <= scan_vld_next;
            scan_found_reg <= scan_found_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_data_reg   <= rsp_data_next;
        end
    end

endmodule

>>> rtl/taps_chk.sv
// Port-level assertion checker for the sequencer top level, with its bind.
module taps_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input taps_pkg::taps_rsp_t rsp_data
);
    import taps_pkg::*;

    // stalled response keeps its transfer pending
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data))
        else $error("response changed while stalled");

    // one command at a time: no back-to-back command transfers
    a_cmd_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while previous one in progress");

    // every pump transition consumed a step
    a_pump_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.pump_transitions <= rsp_data.step_position))
        else $error("pump transitions exceed consumed steps");

    // context, plan and step errors only come with a failed run
    a_err_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_data.error_code == ER_CONTEXT) ||
                      (rsp_data.error_code == ER_PLAN) ||
                      (rsp_data.error_code == ER_STEP))
        |-> (rsp_data.run_state == ST_FAILED))
        else $error("error code without failed run state");

endmodule

bind timed_action_plan_sequencer_top taps_chk u_taps_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

>>> tb/taps_step_checker.sv
`timescale 1ns / 1ps
// Transfer monitor, response predictor and comparator for the plan sequencer.
module taps_step_checker
    import taps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    taps_cmd_if  cmd,
    taps_rsp_if  rsp,
    output int   errors,
    output int   pending
);

    // predicted block state
    plan_entry_t plan_mem [MAX_STEPS];
    logic [4:0]  plan_len;
    run_state_t  run_st;
    err_t        last_err;
    logic [4:0]  step_pos;
    logic        wait_on;
    logic [31:0] wait_t0;
    logic [31:0] done_ms;
    logic [31:0] progress_ms;
    logic        pump_req;
    logic        pump_on;
    logic [7:0]  pump_unit;
    logic [4:0]  pump_cnt;

    taps_rsp_t   due_rsp [$];
    taps_rsp_t   want;

    function automatic logic run_live();
        return run_st == ST_READY || run_st == ST_RUNNING || run_st == ST_WAITING;
    endfunction

    function automatic void clear_run();
        plan_len    = '0;
        run_st      = ST_IDLE;
        last_err    = ER_NONE;
        step_pos    = '0;
        wait_on     = 1'b0;
        wait_t0     = '0;
        done_ms     = '0;
        progress_ms = '0;
        pump_req    = 1'b0;
        pump_on     = 1'b0;
        pump_unit   = '0;
        pump_cnt    = '0;
    endfunction

    function automatic void close_run(input run_state_t st, input err_t er,
                                      input logic [31:0] now);
        run_st      = st;
        last_err    = er;
        done_ms     = now;
        progress_ms = now;
        wait_on     = 1'b0;
    endfunction

    function automatic void step_over(input logic [31:0] now);
        step_pos    = step_pos + 5'd1;
        progress_ms = now;
        if (step_pos >= plan_len)
            close_run(ST_SUCCEEDED, ER_NONE, now);
    endfunction

    // Consume the entry at the current position; 0 when a wait has not run out.
    function automatic logic take_entry(input logic [31:0] now);
        plan_entry_t e;
        logic [31:0] elapsed;
        if (step_pos < MAX_STEPS)
            e = plan_mem[step_pos[3:0]];
        else
            e = '0;
        elapsed = now - wait_t0;
        if (e.action == ACT_NONE)
        begin
            close_run(ST_FAILED, ER_STEP, now);
            return 1'b1;
        end
        if (e.action == ACT_WAIT)
        begin
            if (!wait_on)
            begin
                wait_on     = 1'b1;
                wait_t0     = now;
                run_st      = ST_WAITING;
                progress_ms = now;
                return 1'b1;
            end
            if (elapsed < e.delay)
                return 1'b0;
            wait_on = 1'b0;
            run_st  = ST_RUNNING;
            step_over(now);
            return 1'b1;
        end
        if (e.action == ACT_PUMP_ON || e.action == ACT_PUMP_OFF)
        begin
            pump_req  = 1'b1;
            pump_unit = e.unit;
            pump_on   = (e.action == ACT_PUMP_ON);
            if (pump_cnt != 5'd31)
                pump_cnt = pump_cnt + 5'd1;
        end
        step_over(now);
        return 1'b1;
    endfunction

    function automatic taps_rsp_t predict_step(input taps_cmd_t c);
        taps_rsp_t r;
        logic      ok;
        ok = 1'b0;
        case (c.mode)
            MODE_WRITE:
            begin
                if (!run_live())
                begin
                    plan_mem[c.entry_index] = {c.entry_action, c.entry_delay_ms, c.entry_unit};
                    ok = 1'b1;
                end
            end
            MODE_LOAD:
            begin
                if (run_live())
                    last_err = ER_BUSY;
                else
                begin
                    clear_run();
                    if (!c.ids_ok)
                        close_run(ST_FAILED, ER_CONTEXT, c.now_ms);
                    else if (!c.plan_ok || c.plan_length > MAX_STEPS)
                        close_run(ST_FAILED, ER_PLAN, c.now_ms);
                    else
                    begin
                        plan_len    = 5'(c.plan_length);
                        run_st      = ST_READY;
                        progress_ms = c.now_ms;
                        pump_req    = c.plan_needs_pump;
                        // first pump entry of the plan names the unit
                        for (int i = 0; i < int'(c.plan_length); i++)
                        begin
                            if (plan_mem[i].action == ACT_PUMP_ON ||
                                plan_mem[i].action == ACT_PUMP_OFF)
                            begin
                                pump_unit = plan_mem[i].unit;
                                break;
                            end
                        end
                        ok = 1'b1;
                    end
                end
            end
            MODE_TICK:
            begin
                if (run_st == ST_READY)
                begin
                    run_st      = ST_RUNNING;
                    progress_ms = c.now_ms;
                    ok          = 1'b1;
                end
                else if (run_st == ST_RUNNING || run_st == ST_WAITING)
                begin
                    if (step_pos >= plan_len)
                    begin
                        close_run(ST_SUCCEEDED, ER_NONE, c.now_ms);
                        ok = 1'b1;
                    end
                    else
                        ok = take_entry(c.now_ms);
                end
            end
            default:
            begin
                if (run_live())
                begin
                    run_st      = ST_CANCELLED;
                    done_ms     = c.now_ms;
                    progress_ms = c.now_ms;
                    wait_on     = 1'b0;
                    ok          = 1'b1;
                end
            end
        endcase
        r.accepted          = ok;
        r.run_state         = run_st;
        r.error_code        = last_err;
        r.step_position     = step_pos;
        r.pump_required     = pump_req;
        r.pump_planned_on   = pump_on;
        r.pump_unit         = pump_unit;
        r.pump_transitions  = pump_cnt;
        r.progress_time_ms  = progress_ms;
        r.completed_time_ms = done_ms;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_run();
            for (int i = 0; i < MAX_STEPS; i++)
                plan_mem[i] = '0;
            due_rsp.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual %h",
                             $time, rsp.data);
                    errors++;
                end
                else
                begin
                    want = due_rsp.pop_front();
                    compare_field("accepted", want.accepted, rsp.data.accepted);
                    compare_field("run_state", want.run_state, rsp.data.run_state);
                    compare_field("error_code", want.error_code, rsp.data.error_code);
                    compare_field("step_position", want.step_position,
                                  rsp.data.step_position);
                    compare_field("pump_required", want.pump_required,
                                  rsp.data.pump_required);
                    compare_field("pump_planned_on", want.pump_planned_on,
                                  rsp.data.pump_planned_on);
                    compare_field("pump_unit", want.pump_unit, rsp.data.pump_unit);
                    compare_field("pump_transitions", want.pump_transitions,
                                  rsp.data.pump_transitions);
                    compare_field("progress_time_ms", want.progress_time_ms,
                                  rsp.data.progress_time_ms);
                    compare_field("completed_time_ms", want.completed_time_ms,
                                  rsp.data.completed_time_ms);
                end
            end
            if (cmd.valid && cmd.ready)
                due_rsp.push_back(predict_step(cmd.data));
            pending <= due_rsp.size();
        end
    end

endmodule

>>> tb/tb_timed_action_plan_sequencer_top.sv
`timescale 1ns / 1ps
// Top of the plan sequencer testbench: clock, reset, command traffic, sink stalls, verdict.
module tb_timed_action_plan_sequencer_top;
    import taps_pkg::*;

    // Pass actions are any code from 4 up; the block treats them all alike.
    localparam logic [ACT_W-1:0] ACT_PASS_LO = 3'd4;
    localparam logic [ACT_W-1:0] ACT_PASS_HI = 3'd7;

    localparam int RESET_CYCLES = 6;
    localparam int ITEM_TARGET  = 620;    // ignored ticks and refusals are in here too
    localparam int HOLD_CYCLES  = 400;    // long sink hold-off, fills the block up
    localparam int DRAIN_CYCLES = 40;     // worst load scan plus response register
    localparam int TIMEOUT_NS   = 5_000_000;

    // Stall styles of the response sink, chosen per stretch of cycles.
    typedef enum int {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_PERIODIC} sink_style_t;

    logic clk = 1'b0;
    logic rst_n;

    taps_cmd_if cmd_bus ();
    taps_rsp_if rsp_bus ();

    int fail_count;
    int pending;
    int sent;
    int burst_left;
    logic [31:0] now_q;

    timed_action_plan_sequencer_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // The checker watches both channels and keeps its own copy of the plan state.
    taps_step_checker step_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_bus),
        .rsp     (rsp_bus),
        .errors  (fail_count),
        .pending (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Command builders. Fields the mode ignores carry random noise so
    // that every payload bit toggles over the run.
    // ------------------------------------------------------------------
    function automatic taps_cmd_t noise_fields();
        taps_cmd_t c;
        c.mode            = 2'($urandom_range(0, 3));
        c.now_ms          = $urandom;
        c.entry_index     = 4'($urandom_range(0, 15));
        c.entry_action    = 3'($urandom_range(0, 7));
        c.entry_delay_ms  = $urandom;
        c.entry_unit      = 8'($urandom_range(0, 255));
        c.plan_length     = 8'($urandom_range(0, 255));
        c.plan_needs_pump = 1'($urandom_range(0, 1));
        c.plan_ok         = 1'($urandom_range(0, 1));
        c.ids_ok          = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic taps_cmd_t write_cmd(input logic [3:0] slot, input logic [2:0] act,
                                            input logic [31:0] dly, input logic [7:0] unit);
        taps_cmd_t c;
        c                = noise_fields();
        c.mode           = MODE_WRITE;
        c.entry_index    = slot;
        c.entry_action   = act;
        c.entry_delay_ms = dly;
        c.entry_unit     = unit;
        return c;
    endfunction

    function automatic taps_cmd_t load_cmd(input logic [7:0] len, input logic needs_pump,
                                           input logic good_plan, input logic good_ids,
                                           input logic [31:0] now);
        taps_cmd_t c;
        c                 = noise_fields();
        c.mode            = MODE_LOAD;
        c.now_ms          = now;
        c.plan_length     = len;
        c.plan_needs_pump = needs_pump;
        c.plan_ok         = good_plan;
        c.ids_ok          = good_ids;
        return c;
    endfunction

    function automatic taps_cmd_t tick_cmd(input logic [31:0] now);
        taps_cmd_t c;
        c        = noise_fields();
        c.mode   = MODE_TICK;
        c.now_ms = now;
        return c;
    endfunction

    function automatic taps_cmd_t cancel_cmd(input logic [31:0] now);
        taps_cmd_t c;
        c        = noise_fields();
        c.mode   = MODE_CANCEL;
        c.now_ms = now;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, a random gap (often none) before
    // each burst. valid only drops when a real gap follows, so a burst
    // keeps it high across back-to-back transfers.
    // ------------------------------------------------------------------
    task automatic push_cmd(input taps_cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                cmd_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_bus.valid <= 1'b1;
        cmd_bus.data  <= c;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        sent++;
    endtask

    // Sender goes quiet until every predicted response has been seen.
    task automatic drain_all();
        cmd_bus.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int         r;
        int         len;
        int         n_ticks;
        logic [2:0] act;
        logic [31:0] dly;

        sent       = 0;
        burst_left = 0;
        now_q      = '0;
        rst_n         <= 1'b0;
        cmd_bus.valid <= 1'b0;
        cmd_bus.data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // Small plan: wait 5 ms, pump on at unit 255, pump off at unit 0, a pass.
        push_cmd(write_cmd(4'd0, ACT_WAIT, 32'd5, 8'd0));
        push_cmd(write_cmd(4'd1, ACT_PUMP_ON, 32'hFFFF_FFFF, 8'd255));
        push_cmd(write_cmd(4'd2, ACT_PUMP_OFF, 32'd0, 8'd0));
        push_cmd(write_cmd(4'd3, ACT_PASS_HI, 32'd0, 8'd17));
        // Rejected loads: bad identifiers, bad plan flag, plan longer than the store.
        push_cmd(load_cmd(8'd4, 1'b1, 1'b1, 1'b0, 32'd100));
        push_cmd(load_cmd(8'd4, 1'b1, 1'b0, 1'b1, 32'd200));
        push_cmd(load_cmd(8'd17, 1'b0, 1'b1, 1'b1, 32'd300));
        // Good load just before the millisecond counter wraps.
        push_cmd(load_cmd(8'd4, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFF0));
        push_cmd(load_cmd(8'd2, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFF0));  // busy
        push_cmd(write_cmd(4'd0, ACT_NONE, 32'd0, 8'd0));           // refused, run active
        push_cmd(tick_cmd(32'hFFFF_FFF0));                          // ready -> running
        push_cmd(tick_cmd(32'hFFFF_FFF0));                          // arm the wait
        push_cmd(tick_cmd(32'hFFFF_FFF2));                          // not yet elapsed
        push_cmd(tick_cmd(32'h0000_0010));                          // elapsed across wrap
        push_cmd(tick_cmd(32'h0000_0011));                          // pump on
        push_cmd(tick_cmd(32'h0000_0012));                          // pump off
        push_cmd(tick_cmd(32'h0000_0013));                          // pass, plan done
        push_cmd(tick_cmd(32'h0000_0014));                          // nothing to run
        push_cmd(cancel_cmd(32'h0000_0015));                        // nothing to cancel
        // Empty plan: one tick to start, one to finish.
        push_cmd(write_cmd(4'd0, ACT_NONE, 32'd0, 8'd0));
        push_cmd(load_cmd(8'd0, 1'b0, 1'b1, 1'b1, 32'd40));
        push_cmd(tick_cmd(32'd41));
        push_cmd(tick_cmd(32'd42));
        // Plan whose only entry has no action fails on that step.
        push_cmd(load_cmd(8'd1, 1'b0, 1'b1, 1'b1, 32'd50));
        push_cmd(tick_cmd(32'd51));
        push_cmd(tick_cmd(32'd52));
        // Cancel a run that is still waiting to start.
        push_cmd(load_cmd(8'd1, 1'b1, 1'b1, 1'b1, 32'd60));
        push_cmd(cancel_cmd(32'd61));
        drain_all();

        // --- random part ---
        // Fill the whole store once while idle; from here on every slot a
        // load or tick can reach holds written data.
        for (int i = 0; i < MAX_STEPS; i++)
            push_cmd(write_cmd(4'(i), 3'($urandom_range(1, 7)), $urandom,
                               8'($urandom_range(0, 255))));

        now_q = 32'd1000;
        while (sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // Well-formed run: write a plan, load it, tick it through.
                if ($urandom_range(0, 7) == 0)
                    now_q = ($urandom_range(0, 1) == 1) ? $urandom
                                                        : 32'hFFFF_FFFF - $urandom_range(0, 200);
                len = ($urandom_range(0, 5) == 0) ? MAX_STEPS : $urandom_range(0, MAX_STEPS);
                for (int i = 0; i < len; i++)
                begin
                    r = $urandom_range(0, 15);
                    if (r == 0)
                        act = ACT_NONE;
                    else if (r <= 4)
                        act = ACT_WAIT;
                    else if (r <= 7)
                        act = ACT_PUMP_ON;
                    else if (r <= 10)
                        act = ACT_PUMP_OFF;
                    else
                        act = 3'($urandom_range(ACT_PASS_LO, ACT_PASS_HI));
                    // mostly short waits, some zero, a few huge ones that never end
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        dly = $urandom;
                    else if (r < 3)
                        dly = 32'd0;
                    else
                        dly = $urandom_range(1, 40);
                    push_cmd(write_cmd(4'(i), act, dly, 8'($urandom_range(0, 255))));
                end
                push_cmd(load_cmd(8'(len), 1'($urandom_range(0, 1)), 1'b1, 1'b1, now_q));
                n_ticks = 3 * len + 4;
                repeat (n_ticks)
                begin
                    now_q = now_q + $urandom_range(0, 15);
                    r = $urandom_range(0, 39);
                    if (r == 0)
                        push_cmd(cancel_cmd(now_q));    // cancel mid run
                    else if (r == 1)
                        push_cmd(write_cmd(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                                           $urandom, 8'($urandom_range(0, 255))));
                    else if (r == 2)
                        push_cmd(load_cmd(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                          now_q));
                    else
                        push_cmd(tick_cmd(now_q));
                end
                // leave the block inactive so the next plan write is taken
                push_cmd(cancel_cmd(now_q));
            end
            else
            begin
                // Noise: any mode, any field, then a cancel to close whatever started.
                repeat ($urandom_range(1, 6))
                    push_cmd(noise_fields());
                push_cmd(cancel_cmd(now_q));
            end
            if ($urandom_range(0, 19) == 0)
                drain_all();
        end

        // --- end of run ---
        drain_all();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response sink: stretches of a random stall style. Twice in the run
    // it holds ready low for a long stretch while the sender keeps going,
    // so the response register and then the command side back up.
    // ------------------------------------------------------------------
    initial
    begin : rsp_sink
        sink_style_t style;
        int          span;
        int          taken;
        int          phase;

        taken = 0;
        phase = 0;
        rsp_bus.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            style = sink_style_t'($urandom_range(0, 3));
            span  = $urandom_range(16, 96);
            repeat (span)
            begin
                phase++;
                case (style)
                    SINK_OPEN:     rsp_bus.ready <= 1'b1;
                    SINK_HALF:     rsp_bus.ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:       rsp_bus.ready <= (phase % 3 != 0);
                endcase
                @(posedge clk);
                if (rsp_bus.valid && rsp_bus.ready)
                begin
                    taken++;
                    if (taken == 60 || taken == 400)
                    begin
                        rsp_bus.ready <= 1'b0;
                        repeat (HOLD_CYCLES) @(posedge clk);
                    end
                end
            end
        end
    end

    // Hard stop; far beyond the slowest legal run.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
